// ----- rtl/length_prefixed_record_fifo_macros.svh -----
// assertion macros for the record fifo checker
`ifndef LENGTH_PREFIXED_RECORD_FIFO_MACROS_SVH
`define LENGTH_PREFIXED_RECORD_FIFO_MACROS_SVH

// property must hold at every clock edge out of reset
`define LPRF_ASSERT(name, clk, rstn, prop) \
  name: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("lprf check failed");

// condition must never be seen out of reset
`define LPRF_NEVER(name, clk, rstn, cond) \
  name: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("lprf forbidden condition");

`endif

// ----- rtl/lprf_pkg.sv -----
// shared types and constants of the length-prefixed record fifo
package lprf_pkg;

  localparam int unsigned BufBytes    = 4096;
  localparam int unsigned AddrW       = 12;
  localparam int unsigned LenW        = 13;
  localparam int unsigned HeaderBytes = 4;

  localparam logic [1:0] FUNC_PUSH  = 2'd0;
  localparam logic [1:0] FUNC_POP   = 2'd1;
  localparam logic [1:0] FUNC_CLEAR = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_EMPTY   = 2'd2;
  localparam logic [1:0] ST_INVALID = 2'd3;

  localparam logic [1:0] REG_MODE  = 2'd0;
  localparam logic [1:0] REG_BLOCK = 2'd1;
  localparam logic [1:0] REG_BUF   = 2'd2;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_CLEAR,
    OP_NOP_DONE,
    OP_INVALID,
    OP_FULL,
    OP_RESERVE,
    OP_HDR_WR,
    OP_DATA_WR,
    OP_CONT_WR,
    OP_DROP,
    OP_EMPTY,
    OP_HDR_RD,
    OP_DATA_RD,
    OP_POP_DONE
  } op_e;

  typedef struct packed {
    logic [1:0] func;
    logic       push_idle;
    logic       len_bad;
    logic       fits;
    logic       var_mode;
    logic       dropping;
    logic       has_record;
    logic       pop_idle;
    logic       hdr_last;
    logic       out_busy;
  } dp_status_t;

endpackage

// ----- rtl/lprf_ctrl.sv -----
// sequencer that walks each transaction through an execute step and any header and data steps
module lprf_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                out_ready_i,
  input  lprf_pkg::dp_status_t st_i,
  output lprf_pkg::op_e       op_o,
  output logic                in_ready_o
);

  typedef enum logic [6:0] {
    S_IDLE      = 7'b0000001,
    S_EXEC      = 7'b0000010,
    S_PUSH_HDR  = 7'b0000100,
    S_PUSH_DATA = 7'b0001000,
    S_POP_HDR   = 7'b0010000,
    S_POP_DATA  = 7'b0100000,
    S_POP_WAIT  = 7'b1000000
  } state_e;

  state_e state_d, state_q;

  assign in_ready_o = (state_q == S_IDLE) && (!st_i.out_busy || out_ready_i);

  always_comb begin
    state_d = state_q;
    op_o    = lprf_pkg::OP_NONE;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i && in_ready_o) begin
          op_o    = lprf_pkg::OP_LOAD;
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        state_d = S_IDLE;
        case (st_i.func)
          lprf_pkg::FUNC_PUSH: begin
            if (st_i.push_idle) begin
              if (st_i.len_bad) begin
                op_o = lprf_pkg::OP_INVALID;
              end else if (!st_i.fits) begin
                op_o = lprf_pkg::OP_FULL;
              end else begin
                op_o    = lprf_pkg::OP_RESERVE;
                state_d = st_i.var_mode ? S_PUSH_HDR : S_PUSH_DATA;
              end
            end else if (st_i.dropping) begin
              op_o = lprf_pkg::OP_DROP;
            end else begin
              op_o = lprf_pkg::OP_CONT_WR;
            end
          end
          lprf_pkg::FUNC_POP: begin
            if (!st_i.has_record) begin
              op_o = lprf_pkg::OP_EMPTY;
            end else if (st_i.pop_idle && st_i.var_mode) begin
              state_d = S_POP_HDR;
            end else begin
              state_d = S_POP_DATA;
            end
          end
          lprf_pkg::FUNC_CLEAR: op_o = lprf_pkg::OP_CLEAR;
          default:              op_o = lprf_pkg::OP_NOP_DONE;
        endcase
      end
      S_PUSH_HDR: begin
        op_o = lprf_pkg::OP_HDR_WR;
        if (st_i.hdr_last) state_d = S_PUSH_DATA;
      end
      S_PUSH_DATA: begin
        op_o    = lprf_pkg::OP_DATA_WR;
        state_d = S_IDLE;
      end
      S_POP_HDR: begin
        op_o = lprf_pkg::OP_HDR_RD;
        if (st_i.hdr_last) state_d = S_POP_DATA;
      end
      S_POP_DATA: begin
        op_o    = lprf_pkg::OP_DATA_RD;
        state_d = S_POP_WAIT;
      end
      S_POP_WAIT: begin
        op_o    = lprf_pkg::OP_POP_DONE;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- rtl/lprf_datapath.sv -----
// byte ring, pointers, record counters and result register
module lprf_datapath (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  lprf_pkg::op_e               op_i,
  input  logic                        cfg_wr_i,
  input  logic                        mode_i,
  input  logic [lprf_pkg::LenW-1:0]   block_i,
  input  logic [lprf_pkg::LenW-1:0]   buf_i,
  input  logic [1:0]                  func_i,
  input  logic [7:0]                  data_in_i,
  input  logic [lprf_pkg::LenW-1:0]   record_len_i,
  input  logic                        out_ready_i,
  output lprf_pkg::dp_status_t        st_o,
  output logic                        out_valid_o,
  output logic [1:0]                  status_o,
  output logic [7:0]                  data_out_o,
  output logic [lprf_pkg::LenW-1:0]   record_len_out_o,
  output logic                        last_o,
  output logic                        is_empty_o,
  output logic                        is_full_o
);

  localparam int unsigned AW = lprf_pkg::AddrW;
  localparam int unsigned LW = lprf_pkg::LenW;

  logic [7:0] mem [lprf_pkg::BufBytes];
  logic [7:0] rdata_q;

  logic [1:0]    func_q;
  logic [7:0]    din_q;
  logic [LW-1:0] len_q;
  logic [AW-1:0] rp_q, wp_q;
  logic [LW-1:0] free_q, push_left_q, pop_left_q, pop_len_q, ready_q;
  logic          dropping_q;
  logic [1:0]    cnt_q;
  logic          cap_q;
  logic [1:0]    cap_idx_q;
  logic [LW-1:0] acc_q;

  logic          out_valid_q;
  logic [1:0]    status_q;
  logic [7:0]    dout_q;
  logic [LW-1:0] lout_q;
  logic          last_q;

  logic [LW-1:0] ring_len, blk_len, pl_dec, pop_dec, hdr_len;
  logic [LW:0]   need;
  logic [AW-1:0] wp_nxt, rp_nxt;
  logic [LW-1:0] wp_inc, rp_inc;
  logic [7:0]    hdr_byte, wdata;
  logic          we, clear;

  always_comb begin
    ring_len = buf_i;
    if (buf_i == '0) ring_len = LW'(1);
    if (buf_i > LW'(lprf_pkg::BufBytes)) ring_len = LW'(lprf_pkg::BufBytes);
    blk_len = (block_i == '0) ? LW'(1) : block_i;
  end

  assign wp_inc = {1'b0, wp_q} + LW'(1);
  assign rp_inc = {1'b0, rp_q} + LW'(1);
  assign wp_nxt = (wp_inc >= ring_len) ? '0 : wp_inc[AW-1:0];
  assign rp_nxt = (rp_inc >= ring_len) ? '0 : rp_inc[AW-1:0];

  assign need    = mode_i ? {1'b0, len_q}
                          : {1'b0, len_q} + (LW+1)'(lprf_pkg::HeaderBytes);
  assign pl_dec  = push_left_q - LW'(1);
  assign pop_dec = pop_left_q - LW'(1);
  assign hdr_len = (acc_q == '0) ? LW'(1) : acc_q;

  always_comb begin
    case (cnt_q)
      2'd0:    hdr_byte = len_q[7:0];
      2'd1:    hdr_byte = {3'b000, len_q[LW-1:8]};
      default: hdr_byte = 8'h00;
    endcase
  end

  assign we    = (op_i == lprf_pkg::OP_HDR_WR) || (op_i == lprf_pkg::OP_DATA_WR) ||
                 (op_i == lprf_pkg::OP_CONT_WR);
  assign wdata = (op_i == lprf_pkg::OP_HDR_WR) ? hdr_byte : din_q;
  assign clear = cfg_wr_i || (op_i == lprf_pkg::OP_CLEAR);

  always_comb begin
    st_o.func       = func_q;
    st_o.push_idle  = (push_left_q == '0);
    st_o.len_bad    = mode_i ? (len_q != blk_len) : (len_q == '0);
    st_o.fits       = ({1'b0, free_q} >= need);
    st_o.var_mode   = !mode_i;
    st_o.dropping   = dropping_q;
    st_o.has_record = (pop_left_q != '0) || (ready_q != '0);
    st_o.pop_idle   = (pop_left_q == '0);
    st_o.hdr_last   = (cnt_q == 2'(lprf_pkg::HeaderBytes - 1));
    st_o.out_busy   = out_valid_q;
  end

  always_ff @(posedge clk_i) begin
    if (we) mem[wp_q] <= wdata;
    rdata_q <= mem[rp_q];
  end

  always_ff @(posedge clk_i) begin
    if (op_i == lprf_pkg::OP_LOAD) begin
      func_q <= func_i;
      din_q  <= data_in_i;
      len_q  <= record_len_i;
    end
  end

  // header bytes come back in the cycle after their read is issued
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q     <= 1'b0;
      cap_idx_q <= '0;
      acc_q     <= '0;
    end else begin
      cap_q     <= (op_i == lprf_pkg::OP_HDR_RD);
      cap_idx_q <= cnt_q;
      if (cap_q && cap_idx_q == 2'd0) acc_q[7:0] <= rdata_q;
      if (cap_q && cap_idx_q == 2'd1) acc_q[LW-1:8] <= rdata_q[LW-9:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rp_q        <= '0;
      wp_q        <= '0;
      free_q      <= LW'(lprf_pkg::BufBytes);
      push_left_q <= '0;
      pop_left_q  <= '0;
      pop_len_q   <= '0;
      ready_q     <= '0;
      dropping_q  <= 1'b0;
      cnt_q       <= '0;
    end else if (clear) begin
      rp_q        <= '0;
      wp_q        <= '0;
      free_q      <= ring_len;
      push_left_q <= '0;
      pop_left_q  <= '0;
      pop_len_q   <= '0;
      ready_q     <= '0;
      dropping_q  <= 1'b0;
      cnt_q       <= '0;
    end else begin
      case (op_i)
        lprf_pkg::OP_LOAD: cnt_q <= '0;
        lprf_pkg::OP_FULL: begin
          push_left_q <= len_q - LW'(1);
          dropping_q  <= (len_q != LW'(1));
        end
        lprf_pkg::OP_RESERVE: begin
          push_left_q <= len_q - LW'(1);
          dropping_q  <= 1'b0;
          free_q      <= free_q - need[LW-1:0];
        end
        lprf_pkg::OP_HDR_WR: begin
          wp_q  <= wp_nxt;
          cnt_q <= cnt_q + 2'd1;
        end
        lprf_pkg::OP_DATA_WR: begin
          wp_q <= wp_nxt;
          if (push_left_q == '0) ready_q <= ready_q + LW'(1);
        end
        lprf_pkg::OP_CONT_WR: begin
          wp_q        <= wp_nxt;
          push_left_q <= pl_dec;
          if (pl_dec == '0) ready_q <= ready_q + LW'(1);
        end
        lprf_pkg::OP_DROP: begin
          push_left_q <= pl_dec;
          if (pl_dec == '0) dropping_q <= 1'b0;
        end
        lprf_pkg::OP_HDR_RD: begin
          rp_q   <= rp_nxt;
          free_q <= free_q + LW'(1);
          cnt_q  <= cnt_q + 2'd1;
        end
        lprf_pkg::OP_DATA_RD: begin
          rp_q   <= rp_nxt;
          free_q <= free_q + LW'(1);
          if (pop_left_q == '0) begin
            pop_left_q <= mode_i ? blk_len : hdr_len;
            pop_len_q  <= mode_i ? blk_len : hdr_len;
            ready_q    <= ready_q - LW'(1);
          end
        end
        lprf_pkg::OP_POP_DONE: pop_left_q <= pop_dec;
        default: ;
      endcase
    end
  end

  // result register, held until the sink takes it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      status_q    <= lprf_pkg::ST_OK;
      dout_q      <= '0;
      lout_q      <= '0;
      last_q      <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      if (op_i == lprf_pkg::OP_CLEAR || op_i == lprf_pkg::OP_NOP_DONE ||
          op_i == lprf_pkg::OP_INVALID || op_i == lprf_pkg::OP_FULL ||
          op_i == lprf_pkg::OP_DATA_WR || op_i == lprf_pkg::OP_CONT_WR ||
          op_i == lprf_pkg::OP_DROP || op_i == lprf_pkg::OP_EMPTY ||
          op_i == lprf_pkg::OP_POP_DONE) begin
        out_valid_q <= 1'b1;
        dout_q      <= '0;
        lout_q      <= '0;
        last_q      <= 1'b0;
        case (op_i)
          lprf_pkg::OP_INVALID: status_q <= lprf_pkg::ST_INVALID;
          lprf_pkg::OP_FULL:    status_q <= lprf_pkg::ST_FULL;
          lprf_pkg::OP_DROP:    status_q <= lprf_pkg::ST_FULL;
          lprf_pkg::OP_EMPTY:   status_q <= lprf_pkg::ST_EMPTY;
          lprf_pkg::OP_POP_DONE: begin
            status_q <= lprf_pkg::ST_OK;
            dout_q   <= rdata_q;
            lout_q   <= pop_len_q;
            last_q   <= (pop_dec == '0);
          end
          default: status_q <= lprf_pkg::ST_OK;
        endcase
      end
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = status_q;
  assign data_out_o       = dout_q;
  assign record_len_out_o = lout_q;
  assign last_o           = last_q;
  assign is_empty_o       = (ready_q == '0) && (pop_left_q == '0);
  assign is_full_o        = mode_i ? (free_q < blk_len)
                                   : (free_q < LW'(lprf_pkg::HeaderBytes + 1));

endmodule

// ----- rtl/length_prefixed_record_fifo.sv -----
// Length-prefixed record fifo: a ring of up to 4096 bytes storing whole records, popped
// one byte per transaction. Each transaction is taken, executed and its result registered; a
// push that starts a record adds a data step, after a 4-byte length header in variable
// mode written through the single memory write port; a pop adds data and wait steps, after
// reading the header of a variable-mode record through the one read port. A result waits
// in an output register; the next transaction is taken when it is consumed. Writing any
// register clears the ring.
module length_prefixed_record_fifo (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  output logic        s_tready_o,
  input  logic [23:0] s_tdata_i,   // data_in[7:0], record_len[20:8], zero[23:21]
  input  logic [1:0]  s_tuser_i,   // func[1:0]
  output logic        m_tvalid_o,
  input  logic        m_tready_i,
  output logic [23:0] m_tdata_o,   // data_out[7:0], record_len_out[20:8], is_empty[21],
                                   // is_full[22], zero[23]
  output logic [1:0]  m_tuser_o,   // status[1:0]
  output logic        m_tlast_o,   // last
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned LW = lprf_pkg::LenW;

  logic          mode_q;
  logic [LW-1:0] block_q, buf_q;
  logic          cfg_wr;
  logic          cfg_clr_q;
  logic [1:0]    reg_idx;
  lprf_pkg::op_e op;
  lprf_pkg::dp_status_t st;
  logic [LW-1:0] lout;
  logic          empty, full;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= 1'b0;
      block_q <= LW'(1);
      buf_q   <= LW'(lprf_pkg::BufBytes);
    end else if (cfg_wr) begin
      case (reg_idx)
        lprf_pkg::REG_MODE:  mode_q  <= pwdata[0];
        lprf_pkg::REG_BLOCK: block_q <= pwdata[LW-1:0];
        lprf_pkg::REG_BUF:   buf_q   <= pwdata[LW-1:0];
        default: ;
      endcase
    end
  end

  // ring clear follows a register write in the next cycle so it sees the new length
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_clr_q <= 1'b0;
    end else begin
      cfg_clr_q <= cfg_wr && (reg_idx != 2'd3);
    end
  end

  always_comb begin
    case (reg_idx)
      lprf_pkg::REG_MODE:  prdata = {31'd0, mode_q};
      lprf_pkg::REG_BLOCK: prdata = {{(32-LW){1'b0}}, block_q};
      lprf_pkg::REG_BUF:   prdata = {{(32-LW){1'b0}}, buf_q};
      default:             prdata = '0;
    endcase
  end

  lprf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_tvalid_i),
    .out_ready_i (m_tready_i),
    .st_i        (st),
    .op_o        (op),
    .in_ready_o  (s_tready_o)
  );

  lprf_datapath u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .op_i             (op),
    .cfg_wr_i         (cfg_clr_q),
    .mode_i           (mode_q),
    .block_i          (block_q),
    .buf_i            (buf_q),
    .func_i           (s_tuser_i),
    .data_in_i        (s_tdata_i[7:0]),
    .record_len_i     (s_tdata_i[20:8]),
    .out_ready_i      (m_tready_i),
    .st_o             (st),
    .out_valid_o      (m_tvalid_o),
    .status_o         (m_tuser_o),
    .data_out_o       (m_tdata_o[7:0]),
    .record_len_out_o (lout),
    .last_o           (m_tlast_o),
    .is_empty_o       (empty),
    .is_full_o        (full)
  );

  assign m_tdata_o[20:8] = lout;
  assign m_tdata_o[21]   = empty;
  assign m_tdata_o[22]   = full;
  assign m_tdata_o[23]   = 1'b0;

endmodule

// ----- rtl/lprf_checker.sv -----
// port-level checks of the record fifo, bound to the top level
`include "length_prefixed_record_fifo_macros.svh"

module lprf_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_tready_o,
  input logic        m_tvalid_o,
  input logic        m_tready_i,
  input logic [23:0] m_tdata_o,
  input logic [1:0]  m_tuser_o,
  input logic        m_tlast_o
);

  `LPRF_ASSERT(a_hold_valid, clk_i, rst_ni, m_tvalid_o && !m_tready_i |=> m_tvalid_o)
  `LPRF_NEVER(a_no_take_when_blocked, clk_i, rst_ni, s_tready_o && m_tvalid_o && !m_tready_i)
  `LPRF_ASSERT(a_last_is_ok, clk_i, rst_ni, m_tvalid_o && m_tlast_o |-> m_tuser_o == lprf_pkg::ST_OK)
  `LPRF_ASSERT(a_empty_flag, clk_i, rst_ni, m_tvalid_o && m_tuser_o == lprf_pkg::ST_EMPTY |-> m_tdata_o[21] && m_tdata_o[7:0] == 8'h00)

endmodule

bind length_prefixed_record_fifo lprf_checker u_lprf_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .s_tready_o (s_tready_o),
  .m_tvalid_o (m_tvalid_o),
  .m_tready_i (m_tready_i),
  .m_tdata_o  (m_tdata_o),
  .m_tuser_o  (m_tuser_o),
  .m_tlast_o  (m_tlast_o)
);

// ----- test/tb_length_prefixed_record_fifo.sv -----
// self-checking testbench for the length-prefixed record fifo
module tb_length_prefixed_record_fifo;

  localparam int unsigned StallLimit = 20000;
  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  data;
    logic [12:0] len;
    logic        last;
    logic        empty;
    logic        full;
  } fifo_result_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_tvalid_i;
  logic        s_tready_o;
  logic [23:0] s_tdata_i;
  logic [1:0]  s_tuser_i;
  logic        m_tvalid_o;
  logic        m_tready_i;
  logic [23:0] m_tdata_o;
  logic [1:0]  m_tuser_o;
  logic        m_tlast_o;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  length_prefixed_record_fifo dut (.*);

  // model state
  logic [7:0]  ring_mem [lprf_pkg::BufBytes];
  logic [12:0] rd_ptr, wr_ptr, free_n, push_rem, pop_rem, pop_len, ready_n;
  logic        dropping;
  logic        cfg_mode;
  logic [12:0] cfg_block, cfg_buf;

  fifo_result_t expected_q[$];
  int unsigned  errors;
  int unsigned  send_idle_pct, recv_idle_pct;
  int unsigned  hold_cycles;
  int unsigned  quiet_cycles;

  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  function automatic logic [12:0] ring_size();
    if (cfg_buf == 0) return 13'd1;
    if (cfg_buf > lprf_pkg::BufBytes) return 13'(lprf_pkg::BufBytes);
    return cfg_buf;
  endfunction

  function automatic logic [12:0] fixed_len();
    return (cfg_block == 0) ? 13'd1 : cfg_block;
  endfunction

  function automatic logic [12:0] next_ptr(logic [12:0] p);
    return (p + 13'd1 >= ring_size()) ? 13'd0 : p + 13'd1;
  endfunction

  function automatic void ring_reset();
    rd_ptr = 0; wr_ptr = 0; free_n = ring_size();
    push_rem = 0; dropping = 0; pop_rem = 0; pop_len = 0; ready_n = 0;
  endfunction

  function automatic void ring_put(logic [7:0] v);
    ring_mem[wr_ptr[11:0]] = v;
    wr_ptr = next_ptr(wr_ptr);
  endfunction

  function automatic logic [7:0] ring_get();
    logic [7:0] v;
    v = ring_mem[rd_ptr[11:0]];
    rd_ptr = next_ptr(rd_ptr);
    free_n = free_n + 13'd1;
    return v;
  endfunction

  function automatic logic [1:0] push_byte(logic [7:0] d, logic [12:0] len);
    logic [13:0] need;
    if (push_rem == 0) begin
      if (cfg_mode) begin
        if (len != fixed_len()) return lprf_pkg::ST_INVALID;
        need = {1'b0, len};
      end else begin
        if (len == 0) return lprf_pkg::ST_INVALID;
        need = {1'b0, len} + 14'(lprf_pkg::HeaderBytes);
      end
      push_rem = len - 13'd1;
      if ({1'b0, free_n} < need) begin
        dropping = (push_rem != 0);
        return lprf_pkg::ST_FULL;
      end
      free_n = free_n - need[12:0];
      dropping = 1'b0;
      if (!cfg_mode) begin
        for (int i = 0; i < lprf_pkg::HeaderBytes; i++) ring_put(8'(32'(len) >> (8 * i)));
      end
      ring_put(d);
      if (push_rem == 0) ready_n++;
      return lprf_pkg::ST_OK;
    end
    push_rem--;
    if (dropping) begin
      if (push_rem == 0) dropping = 1'b0;
      return lprf_pkg::ST_FULL;
    end
    ring_put(d);
    if (push_rem == 0) ready_n++;
    return lprf_pkg::ST_OK;
  endfunction

  function automatic fifo_result_t fifo_predict(logic [1:0] func, logic [7:0] d,
                                                logic [12:0] len);
    fifo_result_t r;
    logic [31:0]  hdr;
    r = '0;
    r.status = lprf_pkg::ST_OK;
    if (func == lprf_pkg::FUNC_PUSH) begin
      r.status = push_byte(d, len);
    end else if (func == lprf_pkg::FUNC_POP) begin
      if (pop_rem == 0 && ready_n == 0) begin
        r.status = lprf_pkg::ST_EMPTY;
      end else begin
        if (pop_rem == 0) begin
          if (!cfg_mode) begin
            hdr = '0;
            for (int i = 0; i < lprf_pkg::HeaderBytes; i++) begin
              hdr |= 32'(ring_get()) << (8 * i);
            end
            pop_len = hdr[12:0];
          end else begin
            pop_len = fixed_len();
          end
          if (pop_len == 0) pop_len = 13'd1;
          pop_rem = pop_len;
          ready_n--;
        end
        r.data = ring_get();
        pop_rem--;
        r.len = pop_len;
        r.last = (pop_rem == 0);
      end
    end else if (func == lprf_pkg::FUNC_CLEAR) begin
      ring_reset();
    end
    r.full = cfg_mode ? (free_n < fixed_len()) : (free_n < 13'(lprf_pkg::HeaderBytes + 1));
    r.empty = (ready_n == 0 && pop_rem == 0);
    return r;
  endfunction

  // result checker
  always @(posedge clk_i) begin
    fifo_result_t got, exp_r;
    if (rst_ni && m_tvalid_o && m_tready_i) begin
      got = {m_tuser_o, m_tdata_o[7:0], m_tdata_o[20:8], m_tlast_o, m_tdata_o[21],
             m_tdata_o[22]};
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
      end else begin
        exp_r = expected_q.pop_front();
        if (got.status != exp_r.status) begin
          $display("%0t: status exp %0d got %0d", $time, exp_r.status, got.status);
          errors++;
        end
        if (got.data != exp_r.data) begin
          $display("%0t: data exp %h got %h", $time, exp_r.data, got.data);
          errors++;
        end
        if (got.len != exp_r.len) begin
          $display("%0t: record len exp %0d got %0d", $time, exp_r.len, got.len);
          errors++;
        end
        if (got.last != exp_r.last) begin
          $display("%0t: last exp %0d got %0d", $time, exp_r.last, got.last);
          errors++;
        end
        if (got.empty != exp_r.empty) begin
          $display("%0t: empty exp %0d got %0d", $time, exp_r.empty, got.empty);
          errors++;
        end
        if (got.full != exp_r.full) begin
          $display("%0t: full exp %0d got %0d", $time, exp_r.full, got.full);
          errors++;
        end
      end
    end
  end

  // receiver side, with an optional long hold-off
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      m_tready_i <= 1'b0;
    end else if (hold_cycles > 0) begin
      m_tready_i <= 1'b0;
      hold_cycles--;
    end else begin
      m_tready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    if ((s_tvalid_i && s_tready_o) || (m_tvalid_o && m_tready_i) || psel) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_item(logic [1:0] func, logic [7:0] d, logic [12:0] len);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid_i <= 1'b0;
      @(negedge clk_i);
    end
    s_tvalid_i <= 1'b1;
    s_tuser_i  <= func;
    s_tdata_i  <= {3'b000, len, d};
    do @(posedge clk_i); while (!s_tready_o);
    expected_q.push_back(fifo_predict(func, d, len));
  endtask

  task automatic drain();
    @(negedge clk_i);
    s_tvalid_i <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
  endtask

  task automatic reg_write(logic [1:0] idx, logic [12:0] value);
    drain();
    @(negedge clk_i);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00}; pwdata <= 32'(value);
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    case (idx)
      lprf_pkg::REG_MODE:  cfg_mode = value[0];
      lprf_pkg::REG_BLOCK: cfg_block = value;
      default:             cfg_buf = value;
    endcase
    ring_reset();
    @(negedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  task automatic configure(logic mode, logic [12:0] blk, logic [12:0] buf_len);
    reg_write(lprf_pkg::REG_MODE, 13'(mode));
    reg_write(lprf_pkg::REG_BLOCK, blk);
    reg_write(lprf_pkg::REG_BUF, buf_len);
  endtask

  task automatic push_record(logic [12:0] len, int unsigned pop_pct);
    for (int i = 0; i < len; i++) begin
      send_item(lprf_pkg::FUNC_PUSH, 8'($urandom), (i == 0) ? len : 13'($urandom));
      if ($urandom_range(99) < pop_pct) begin
        send_item(lprf_pkg::FUNC_POP, 8'($urandom), 13'($urandom));
      end
    end
  endtask

  task automatic test_directed();
    send_item(lprf_pkg::FUNC_POP, 8'h00, 13'd0);
    push_record(13'd1, 0);
    send_item(lprf_pkg::FUNC_POP, 8'hff, 13'h1fff);
    send_item(lprf_pkg::FUNC_POP, 8'h00, 13'd0);
    send_item(lprf_pkg::FUNC_PUSH, 8'hff, 13'd0);
    send_item(FUNC_UNUSED, 8'hff, 13'h1fff);
    push_record(13'd3, 0);
    send_item(lprf_pkg::FUNC_CLEAR, 8'h5a, 13'd3);
    send_item(lprf_pkg::FUNC_POP, 8'h00, 13'd0);
    push_record(13'd2, 0);
    repeat (2) send_item(lprf_pkg::FUNC_POP, 8'h00, 13'd0);
    // longest record does not fit beside its header; a clear ends the dropping
    send_item(lprf_pkg::FUNC_PUSH, 8'h33, 13'd4096);
    repeat (3) send_item(lprf_pkg::FUNC_PUSH, 8'h44, 13'd0);
    send_item(lprf_pkg::FUNC_CLEAR, 8'h00, 13'd0);
    push_record(13'd1, 0);
    send_item(lprf_pkg::FUNC_PUSH, 8'h12, 13'h1fff);
    // record larger than the ring: refused, remaining bytes dropped
    configure(1'b0, 13'd1, 13'd16);
    push_record(13'd11, 0);
    push_record(13'd13, 0);
    push_record(13'd1, 0);
    repeat (14) send_item(lprf_pkg::FUNC_POP, 8'h00, 13'd0);
  endtask

  task automatic test_random(int unsigned n_items);
    int unsigned sent, r;
    logic [12:0] len, bad;
    sent = 0;
    while (sent < n_items) begin
      r = $urandom_range(99);
      if (r < 55) begin
        if (cfg_mode && fixed_len() > 13'd256) begin
          // a block this large is refused on its first byte
          send_item(lprf_pkg::FUNC_PUSH, 8'($urandom), fixed_len());
          send_item(lprf_pkg::FUNC_CLEAR, 8'($urandom), 13'($urandom));
          sent += 2;
        end else begin
          if (cfg_mode) len = fixed_len();
          else if ($urandom_range(9) == 0) len = 13'($urandom_range(200, 1));
          else len = 13'($urandom_range(12, 1));
          push_record(len, 25);
          sent += len;
        end
      end else if (r < 85) begin
        repeat ($urandom_range(8, 1)) begin
          send_item(lprf_pkg::FUNC_POP, 8'($urandom), 13'($urandom));
          sent++;
        end
      end else if (r < 92) begin
        bad = 13'($urandom);
        if (cfg_mode && bad == fixed_len()) bad = bad + 13'd1;
        send_item(lprf_pkg::FUNC_PUSH, 8'($urandom), cfg_mode ? bad : 13'd0);
        sent++;
      end else if (r < 96) begin
        send_item(FUNC_UNUSED, 8'($urandom), 13'($urandom));
        sent++;
      end else if (r < 98) begin
        send_item(lprf_pkg::FUNC_CLEAR, 8'($urandom), 13'($urandom));
        sent++;
      end else begin
        send_item(2'($urandom), 8'($urandom), 13'($urandom));
        sent++;
      end
    end
  endtask

  task automatic test_settings();
    configure(1'b0, 13'd1, 13'd4096);
    test_random(150);
    configure(1'b0, 13'd7, 13'd64);
    test_random(250);
    configure(1'b1, 13'd4, 13'd16);
    test_random(150);
    configure(1'b1, 13'd5, 13'd16);
    test_random(150);
    send_idle_pct = 62; recv_idle_pct = 16;
    configure(1'b1, 13'd0, 13'd1);
    test_random(120);
    configure(1'b0, 13'd3, 13'd0);
    test_random(80);
    configure(1'b0, 13'd2, 13'd8191);
    test_random(250);
    send_idle_pct = 0; recv_idle_pct = 0;
    configure(1'b1, 13'd4096, 13'd4095);
    test_random(20);
    configure(1'b1, 13'd8191, 13'd4096);
    test_random(20);
    configure(1'b0, 13'd1, 13'd24);
    test_random(150);
  endtask

  task automatic test_backpressure();
    configure(1'b0, 13'd1, 13'd4096);
    hold_cycles = 400;
    repeat (20) push_record(13'($urandom_range(10, 1)), 30);
    repeat (60) send_item(lprf_pkg::FUNC_POP, 8'($urandom), 13'($urandom));
  endtask

  initial begin
    errors = 0; quiet_cycles = 0; hold_cycles = 0;
    send_idle_pct = 16; recv_idle_pct = 62;
    rst_ni = 1'b0; s_tvalid_i = 1'b0; s_tdata_i = '0; s_tuser_i = '0;
    m_tready_i = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    cfg_mode = 1'b0; cfg_block = 13'd1; cfg_buf = 13'd4096;
    for (int i = 0; i < lprf_pkg::BufBytes; i++) ring_mem[i] = 8'h00;
    ring_reset();
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_directed();
    test_settings();
    test_backpressure();
    drain();
    if (errors == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule
